// ===== hw/rtl/fmjs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmjs_pkg
// Types and constants shared by the feeder mode and jam sequencer.
// ----------------------------------------------------------------------------
package fmjs_pkg;

	localparam logic [31:0] SHOT_TIMEOUT_US = 32'd200000;
	localparam logic [31:0] AUTO_LOAD_SPEED = 32'd655360;

	typedef enum logic [2:0] {
		ACT_TICK       = 3'd0,
		ACT_SHOT_ONCE  = 3'd1,
		ACT_CONT_START = 3'd2,
		ACT_CONT_STOP  = 3'd3,
		ACT_KEY_UPDATE = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_SHOT = 2'd1,
		MODE_CONT = 2'd2
	} feeder_mode_t;

	localparam logic LOOP_SPEED = 1'b0;
	localparam logic LOOP_POS   = 1'b1;

	localparam logic [1:0] PID_NONE  = 2'd0;
	localparam logic [1:0] PID_POS   = 2'd1;
	localparam logic [1:0] PID_SPEED = 2'd2;

	typedef enum logic [2:0] {
		REG_STEP_ANGLE      = 3'd0,
		REG_CONT_SPEED      = 3'd1,
		REG_JAM_THRESHOLD   = 3'd2,
		REG_JAM_DETECT_TIME = 3'd3,
		REG_REVERSE_TIME    = 3'd4,
		REG_REVERSE_SPEED   = 3'd5,
		REG_POS_TOLERANCE   = 3'd6,
		REG_ENABLES         = 3'd7
	} reg_index_t;

	localparam int unsigned ADDR_W = 5;

	localparam logic [31:0] RST_STEP_ANGLE      = 32'd68616;
	localparam logic [31:0] RST_CONT_SPEED      = 32'd32768000;
	localparam logic [31:0] RST_JAM_THRESHOLD   = 32'd6553600;
	localparam logic [31:0] RST_JAM_DETECT_TIME = 32'd1000000;
	localparam logic [31:0] RST_REVERSE_TIME    = 32'd1000000;
	localparam logic [31:0] RST_REVERSE_SPEED   = 32'd65536000;
	localparam logic [30:0] RST_POS_TOLERANCE   = 31'd1311;
	localparam logic [1:0]  RST_ENABLES         = 2'd0;

	localparam int unsigned EN_JAM_CHECK = 0;
	localparam int unsigned EN_AUTO_LOAD = 1;

endpackage

`default_nettype wire

// ===== hw/rtl/fmjs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmjs_if
// Valid/ready channels for feeder commands and tick results.
// ----------------------------------------------------------------------------
interface fmjs_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic signed [31:0] position;
	logic signed [31:0] velocity;
	logic [31:0] now_us;
	logic        key_pressed;

	modport source (output valid, action, position, velocity, now_us, key_pressed,
		input ready);
	modport sink (input valid, action, position, velocity, now_us, key_pressed,
		output ready);
endinterface

interface fmjs_res_if;
	logic        valid;
	logic        ready;
	logic        control_mode;
	logic signed [31:0] setpoint;
	logic signed [31:0] loop_error;
	logic [1:0]  pid_reset;
	logic [1:0]  feeder_state;
	logic        reversing;

	modport source (output valid, control_mode, setpoint, loop_error, pid_reset,
		feeder_state, reversing, input ready);
	modport sink (input valid, control_mode, setpoint, loop_error, pid_reset,
		feeder_state, reversing, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/feeder_mode_and_jam_sequencer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// feeder_mode_and_jam_sequencer_unit
// Feeder mode sequencer with shot, continuous, auto-load and jam reverse.
// ----------------------------------------------------------------------------
// The block accepts one command transaction per clock cycle, but a tick
// waits in the input register while the result register is still held.
// Each transaction is processed from the input register, where the feeder
// state is updated in a single pass. Event actions produce no result; a
// tick produces one result transaction, held in the result register until
// the sink takes it. The rate is set by the state update loop. Configuration
// registers are written and read through the APB port at byte address 4*i.
// ----------------------------------------------------------------------------
module feeder_mode_and_jam_sequencer_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	fmjs_cmd_if.sink                        cmd,
	fmjs_res_if.source                      res,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [fmjs_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import fmjs_pkg::*;

	logic signed [31:0] step_angle_q;
	logic signed [31:0] cont_speed_q;
	logic signed [31:0] jam_threshold_q;
	logic [31:0]        jam_detect_time_q;
	logic [31:0]        reverse_time_q;
	logic signed [31:0] reverse_speed_q;
	logic [30:0]        pos_tolerance_q;
	logic [1:0]         enables_q;

	reg_index_t reg_idx;
	logic       cfg_wr;

	logic               vld_s1;
	logic [2:0]         action_s1;
	logic [31:0]        position_s1;
	logic signed [31:0] velocity_s1;
	logic [31:0]        now_s1;
	logic               key_s1;

	feeder_mode_t mode_q, mode_d;
	logic [31:0]  target_q, target_d;
	logic [31:0]  shot_start_q, shot_start_d;
	logic         prev_loop_q, prev_loop_d;
	logic         key_held_q, key_held_d;
	logic         jam_timing_q, jam_timing_d;
	logic [31:0]  jam_start_q, jam_start_d;

	logic               out_vld_q;
	logic               out_mode_q;
	logic signed [31:0] out_setpoint_q;
	logic signed [31:0] out_error_q;
	logic [1:0]         out_pid_q;
	logic [1:0]         out_state_q;
	logic               out_rev_q;

	logic               is_tick;
	logic               out_free;
	logic               adv;
	logic               loop_sel;
	logic               loop_fin;
	logic signed [31:0] speed_target;
	logic signed [31:0] speed_fin;
	logic [1:0]         pid_flag;
	logic               rev_flag;
	logic signed [31:0] pos_err;
	logic [31:0]        pos_mag;
	logic [31:0]        shot_elapsed;
	logic               jam_run;
	logic               vel_low;
	logic [31:0]        jam_start_eff;
	logic [31:0]        jam_elapsed;
	logic [32:0]        jam_end;
	logic signed [31:0] rev_drive;
	logic signed [32:0] speed_diff;
	logic signed [31:0] speed_err;

	// Configuration port.
	assign pready  = 1'b1;
	assign reg_idx = reg_index_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_angle_q      <= RST_STEP_ANGLE;
			cont_speed_q      <= RST_CONT_SPEED;
			jam_threshold_q   <= RST_JAM_THRESHOLD;
			jam_detect_time_q <= RST_JAM_DETECT_TIME;
			reverse_time_q    <= RST_REVERSE_TIME;
			reverse_speed_q   <= RST_REVERSE_SPEED;
			pos_tolerance_q   <= RST_POS_TOLERANCE;
			enables_q         <= RST_ENABLES;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_STEP_ANGLE:      step_angle_q      <= pwdata;
				REG_CONT_SPEED:      cont_speed_q      <= pwdata;
				REG_JAM_THRESHOLD:   jam_threshold_q   <= pwdata;
				REG_JAM_DETECT_TIME: jam_detect_time_q <= pwdata;
				REG_REVERSE_TIME:    reverse_time_q    <= pwdata;
				REG_REVERSE_SPEED:   reverse_speed_q   <= pwdata;
				REG_POS_TOLERANCE:   pos_tolerance_q   <= pwdata[30:0];
				REG_ENABLES:         enables_q         <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_STEP_ANGLE:      prdata = step_angle_q;
			REG_CONT_SPEED:      prdata = cont_speed_q;
			REG_JAM_THRESHOLD:   prdata = jam_threshold_q;
			REG_JAM_DETECT_TIME: prdata = jam_detect_time_q;
			REG_REVERSE_TIME:    prdata = reverse_time_q;
			REG_REVERSE_SPEED:   prdata = reverse_speed_q;
			REG_POS_TOLERANCE:   prdata = {1'b0, pos_tolerance_q};
			REG_ENABLES:         prdata = {30'd0, enables_q};
			default:             prdata = '0;
		endcase
	end

	// Handshake and input register.
	assign is_tick   = (action_s1 == ACT_TICK);
	assign out_free  = !out_vld_q || res.ready;
	assign adv       = vld_s1 && (!is_tick || out_free);
	assign cmd.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			action_s1   <= cmd.action;
			position_s1 <= cmd.position;
			velocity_s1 <= cmd.velocity;
			now_s1      <= cmd.now_us;
			key_s1      <= cmd.key_pressed;
		end
	end

	// Sequencer.
	assign pos_err       = signed'(target_q - position_s1);
	assign pos_mag       = pos_err[31] ? (32'd0 - pos_err) : pos_err;
	assign shot_elapsed  = now_s1 - shot_start_q;
	assign vel_low       = velocity_s1 < jam_threshold_q;
	assign jam_start_eff = (vel_low && !jam_timing_q) ? now_s1 : jam_start_q;
	assign jam_elapsed   = now_s1 - jam_start_eff;
	assign jam_end       = {1'b0, reverse_time_q} + {1'b0, jam_detect_time_q};
	assign rev_drive     = (reverse_speed_q == 32'sh8000_0000) ? 32'sh7FFF_FFFF
		: -reverse_speed_q;

	always_comb begin
		mode_d       = mode_q;
		target_d     = target_q;
		shot_start_d = shot_start_q;
		prev_loop_d  = prev_loop_q;
		key_held_d   = key_held_q;
		jam_timing_d = jam_timing_q;
		jam_start_d  = jam_start_q;
		loop_sel     = LOOP_SPEED;
		speed_target = '0;
		pid_flag     = PID_NONE;
		rev_flag     = 1'b0;
		loop_fin     = LOOP_SPEED;
		speed_fin    = '0;
		jam_run      = 1'b0;

		case (action_s1)
			ACT_SHOT_ONCE: begin
				if (mode_q != MODE_SHOT) begin
					target_d     = position_s1 + step_angle_q;
					shot_start_d = now_s1;
					mode_d       = MODE_SHOT;
				end
			end
			ACT_CONT_START: mode_d = MODE_CONT;
			ACT_CONT_STOP: begin
				if (mode_q == MODE_CONT) begin
					mode_d = MODE_IDLE;
				end
			end
			ACT_KEY_UPDATE: key_held_d = key_s1;
			ACT_TICK: begin
				case (mode_q)
					MODE_SHOT: begin
						loop_sel = LOOP_POS;
						if (shot_elapsed > SHOT_TIMEOUT_US
							|| pos_mag < {1'b0, pos_tolerance_q}) begin
							mode_d = MODE_IDLE;
						end
					end
					MODE_CONT: speed_target = cont_speed_q;
					default: begin
						if (enables_q[EN_AUTO_LOAD] && !key_held_q) begin
							speed_target = AUTO_LOAD_SPEED;
						end
					end
				endcase

				if (prev_loop_q != loop_sel) begin
					pid_flag = (loop_sel == LOOP_POS) ? PID_POS : PID_SPEED;
				end
				prev_loop_d = loop_sel;
				loop_fin    = loop_sel;
				speed_fin   = speed_target;

				jam_run = enables_q[EN_JAM_CHECK]
					&& (loop_sel == LOOP_POS || speed_target != 32'sd0);
				if (jam_run) begin
					jam_timing_d = vel_low;
					jam_start_d  = jam_start_eff;
					if (vel_low && jam_elapsed > jam_detect_time_q) begin
						loop_fin  = LOOP_SPEED;
						speed_fin = rev_drive;
						rev_flag  = 1'b1;
						if ({1'b0, jam_elapsed} > jam_end) begin
							jam_timing_d = 1'b0;
						end
					end
				end
			end
			default: ;
		endcase
	end

	assign speed_diff = {speed_fin[31], speed_fin} - {velocity_s1[31], velocity_s1};
	assign speed_err  = (speed_diff[32] != speed_diff[31])
		? (speed_diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : speed_diff[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			target_q     <= '0;
			shot_start_q <= '0;
			prev_loop_q  <= LOOP_SPEED;
			key_held_q   <= 1'b0;
			jam_timing_q <= 1'b0;
			jam_start_q  <= '0;
		end else if (adv) begin
			mode_q       <= mode_d;
			target_q     <= target_d;
			shot_start_q <= shot_start_d;
			prev_loop_q  <= prev_loop_d;
			key_held_q   <= key_held_d;
			jam_timing_q <= jam_timing_d;
			jam_start_q  <= jam_start_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= adv && is_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv && is_tick) begin
			out_mode_q     <= loop_fin;
			out_setpoint_q <= (loop_fin == LOOP_POS) ? signed'(target_q) : speed_fin;
			out_error_q    <= (loop_fin == LOOP_POS) ? pos_err : speed_err;
			out_pid_q      <= pid_flag;
			out_state_q    <= mode_d;
			out_rev_q      <= rev_flag;
		end
	end

	assign res.valid        = out_vld_q;
	assign res.control_mode = out_mode_q;
	assign res.setpoint     = out_setpoint_q;
	assign res.loop_error   = out_error_q;
	assign res.pid_reset    = out_pid_q;
	assign res.feeder_state = out_state_q;
	assign res.reversing    = out_rev_q;

	a_tick_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && is_tick |=> out_vld_q)
		else $error("accepted tick did not load the result register");

	a_event_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		!out_vld_q && !(adv && is_tick) |=> !out_vld_q)
		else $error("result appeared without a tick");

	a_reverse_speed_loop: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_rev_q |-> out_mode_q == LOOP_SPEED && out_setpoint_q == rev_drive)
		else $error("reverse drive not in speed loop at reverse speed");

	a_pid_pos_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_pid_q == PID_POS && !out_rev_q |-> out_mode_q == LOOP_POS)
		else $error("position loop reset flagged without position loop");

endmodule

`default_nettype wire
